/* rtl/core/qpsk_carrier_modulator_top_defines.svh */
// assertion macros used by the checker file
// clk and rst_n must be visible where the macros are used
`ifndef QPSK_CARRIER_MODULATOR_TOP_DEFINES_SVH
`define QPSK_CARRIER_MODULATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define QCM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qcm: assertion failed");

// next-cycle implication, disabled while in reset
`define QCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qcm: assertion failed");

`endif

/* rtl/core/qcm_pkg.sv */
`default_nettype none

package qcm_pkg;

  // default elaboration values
  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 10;
  localparam int unsigned SAMPLE_BITS_DEF     = 16;

  // samples per symbol limits
  localparam int unsigned MAX_SAMPLES  = 64;
  localparam int unsigned RESULT_LIMIT = 64;
  localparam int unsigned CNT_MAX      = (MAX_SAMPLES < RESULT_LIMIT) ? MAX_SAMPLES
                                                                      : RESULT_LIMIT;

  // field widths
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned ENERGY_W   = 48;
  localparam int unsigned GAIN_W     = 15;
  localparam int unsigned SPS_W      = 7;
  localparam int unsigned INC_W      = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned OFS_W      = 3;

  // symbol queue depth, power of two
  localparam int unsigned QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INC   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CGAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BGAIN = 2'd3;

  // register reset values
  localparam logic [SPS_W-1:0]  SPS_RST   = 7'd8;
  localparam logic [INC_W-1:0]  INC_RST   = 32'd536870912;
  localparam logic [GAIN_W-1:0] CGAIN_RST = 15'd11585;
  localparam logic [GAIN_W-1:0] BGAIN_RST = 15'd8192;

  // phase offset in eighths of a cycle, by bit pair (i,q)
  localparam logic [OFS_W-1:0] OFS_00 = 3'd1;
  localparam logic [OFS_W-1:0] OFS_01 = 3'd3;
  localparam logic [OFS_W-1:0] OFS_11 = 3'd5;
  localparam logic [OFS_W-1:0] OFS_10 = 3'd7;

  typedef struct packed {
    logic [SPS_W-1:0]  samples_per_symbol;
    logic [INC_W-1:0]  phase_increment;
    logic [GAIN_W-1:0] carrier_gain;
    logic [GAIN_W-1:0] baseband_gain;
  } qcm_cfg_t;

  typedef struct packed {
    logic             bit_i;
    logic             bit_q;
    logic [OFS_W-1:0] offset_code;
    logic [IDX_W-1:0] last_idx;
  } qcm_sym_t;

  // cosine series in Q30: pi/2 and the factorial step divisors
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SERIES_DEN [10] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                              64'd132, 64'd182, 64'd240, 64'd306,
                                              64'd380};

  // one quarter-wave entry, cos(pi/2 * k / 2^addr_bits) * (2^(sample_bits-1) - 1)
  function automatic logic [63:0] qcm_cos_entry(input int unsigned k,
                                                 input int unsigned addr_bits,
                                                 input int unsigned sample_bits);
    logic [63:0]        n;
    logic [63:0]        scale;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic signed [63:0] sum;
    int unsigned        m;
    n     = 64'd1 << addr_bits;
    scale = (64'd1 << (sample_bits - 1)) - 64'd1;
    x     = (64'(k) * HALF_PI_Q30 + (n >> 1)) >> addr_bits;
    x2    = (x * x + (64'd1 << 29)) >> 30;
    term  = 64'd1 << 30;
    sum   = signed'(term);
    for (m = 1; m <= 10; m++) begin
      term = (term * x2 + (64'd1 << 29)) >> 30;
      term = term / SERIES_DEN[m-1];
      if (m[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > signed'(64'd1 << 30)) begin
      sum = signed'(64'd1 << 30);
    end
    prod = unsigned'(sum) * scale + (64'd1 << 29);
    return prod >> 30;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/qcm_if.sv */
`default_nettype none

// symbol channel
interface qcm_sym_if;
  logic valid;
  logic ready;
  logic bit_i;
  logic bit_q;

  modport source (output valid, output bit_i, output bit_q, input ready);
  modport sink (input valid, input bit_i, input bit_q, output ready);
endinterface

// result channel
interface qcm_res_if;
  import qcm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [LEVEL_W-1:0]  carrier_sample;
  logic signed [LEVEL_W-1:0]  in_phase_level;
  logic signed [LEVEL_W-1:0]  quadrature_level;
  logic [IDX_W-1:0]           sample_index;
  logic                       last_of_symbol;
  logic [ENERGY_W-1:0]        baseband_energy;
  logic [ENERGY_W-1:0]        carrier_energy;

  modport source (output valid, output carrier_sample, output in_phase_level,
                  output quadrature_level, output sample_index, output last_of_symbol,
                  output baseband_energy, output carrier_energy, input ready);
  modport sink (input valid, input carrier_sample, input in_phase_level,
                input quadrature_level, input sample_index, input last_of_symbol,
                input baseband_energy, input carrier_energy, output ready);
endinterface

`default_nettype wire

/* rtl/core/qcm_front.sv */
`default_nettype none

module qcm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  qcm_pkg::qcm_cfg_t cfg,
  qcm_sym_if.sink           in_chan,
  output logic              push_valid,
  output qcm_pkg::qcm_sym_t push_entry,
  input  logic              push_ready
);
  import qcm_pkg::*;

  localparam logic [SPS_W-1:0] SPS_CAP  = SPS_W'(CNT_MAX);
  localparam logic [IDX_W-1:0] LAST_CAP = IDX_W'(CNT_MAX - 1);

  logic               hold_valid_r;
  qcm_sym_t           entry_r;
  qcm_sym_t           entry_nxt;
  logic [SPS_W-1:0]   sps_m1;
  logic               accept;

  // classify the symbol: phase offset and last sample index
  always_comb begin
    sps_m1                = cfg.samples_per_symbol - SPS_W'(1);
    entry_nxt.bit_i       = in_chan.bit_i;
    entry_nxt.bit_q       = in_chan.bit_q;
    case ({in_chan.bit_i, in_chan.bit_q})
      2'b00:   entry_nxt.offset_code = OFS_00;
      2'b01:   entry_nxt.offset_code = OFS_01;
      2'b11:   entry_nxt.offset_code = OFS_11;
      default: entry_nxt.offset_code = OFS_10;
    endcase
    if (cfg.samples_per_symbol == '0) begin
      entry_nxt.last_idx = '0;
    end else if (cfg.samples_per_symbol > SPS_CAP) begin
      entry_nxt.last_idx = LAST_CAP;
    end else begin
      entry_nxt.last_idx = sps_m1[IDX_W-1:0];
    end
  end

  // one holding register in front of the queue
  assign in_chan.ready = !hold_valid_r || push_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push_valid    = hold_valid_r;
  assign push_entry    = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept) begin
      hold_valid_r <= 1'b1;
    end else if (push_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/qcm_queue.sv */
`default_nettype none

module qcm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  qcm_pkg::qcm_sym_t push_entry,
  output logic              push_ready,
  output logic              head_valid,
  output qcm_pkg::qcm_sym_t head,
  input  logic              pop
);
  import qcm_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  qcm_sym_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/qcm_back.sv */
`default_nettype none

module qcm_back #(
  parameter int unsigned PHASE_BITS      = qcm_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = qcm_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = qcm_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qcm_pkg::qcm_cfg_t cfg,
  input  logic              head_valid,
  input  qcm_pkg::qcm_sym_t head,
  output logic              pop,
  qcm_res_if.source         out_chan
);
  import qcm_pkg::*;

  localparam int unsigned PB       = PHASE_BITS;
  localparam int unsigned TA       = TABLE_ADDR_BITS;
  localparam int unsigned TAB_N    = 1 << TA;
  localparam int unsigned TAB_SIZE = TAB_N + 1;
  localparam int unsigned TAB_W    = SAMPLE_BITS - 1;
  localparam int unsigned PROD_W   = TAB_W + GAIN_W;
  localparam int unsigned SQ_W     = 2 * GAIN_W;
  localparam int unsigned BBE_W    = SQ_W + 1;

  typedef logic [TAB_W-1:0] qtab_t [TAB_SIZE];

  typedef struct packed {
    logic             bit_i;
    logic             bit_q;
    logic [IDX_W-1:0] idx;
    logic             last;
  } tag_t;

  function automatic qtab_t build_qtab();
    qtab_t       t;
    logic [63:0] e;
    for (int k = 0; k < TAB_SIZE; k++) begin
      e    = qcm_cos_entry(k, TA, SAMPLE_BITS);
      t[k] = e[TAB_W-1:0];
    end
    return t;
  endfunction

  // quarter-wave cosine rom
  localparam qtab_t QTAB = build_qtab();

  logic                      adv;
  logic                      issue;
  logic [IDX_W-1:0]          j_r;
  logic [PB-1:0]             acc_r;
  logic [PB+INC_W-1:0]       inc_wide;
  logic [PB-1:0]             inc;
  logic [PB-1:0]             offset;
  tag_t                      tag_nxt;

  logic                      v1_r, v2_r, v3_r, v4_r, v5_r;
  tag_t                      tag1_r, tag2_r, tag3_r, tag4_r, tag5_r;
  logic [PB-1:0]             p1_r;
  logic [TAB_W-1:0]          tab2_r;
  logic                      neg2_r, neg3_r, neg4_r;
  logic [PROD_W-1:0]         prod3_r;
  logic [GAIN_W-1:0]         r4_r;
  logic [SQ_W-1:0]           sq5_r;
  logic signed [LEVEL_W-1:0] samp5_r;

  logic [1:0]                quad;
  logic [TA-1:0]             tidx;
  logic [TA:0]               taddr;
  logic [PROD_W-1:0]         rnd;
  logic [LEVEL_W-1:0]        r_ext;

  logic [BBE_W-1:0]          bbe_r;
  logic [SQ_W-1:0]           gsq;
  logic [ENERGY_W-1:0]       ben_r, cen_r;
  logic [ENERGY_W:0]         ben_sum, cen_sum;
  logic [ENERGY_W-1:0]       ben_nxt, cen_nxt;
  logic [LEVEL_W-1:0]        lvl_pos;

  logic                      out_valid_r;
  logic signed [LEVEL_W-1:0] carrier_r, ilev_r, qlev_r;
  logic [IDX_W-1:0]          idx_r;
  logic                      last_r;

  // whole pipeline moves while the output slot frees up
  assign adv   = !out_valid_r || out_chan.ready;
  assign issue = adv && head_valid;
  assign pop   = issue && (j_r == head.last_idx);

  // increment rescaled to the accumulator width, offset in eighths of a cycle
  assign inc_wide = {cfg.phase_increment, PB'(0)};
  assign inc      = inc_wide[PB+INC_W-1:INC_W];
  assign offset   = {head.offset_code, (PB - OFS_W)'(0)};

  always_comb begin
    tag_nxt.bit_i = head.bit_i;
    tag_nxt.bit_q = head.bit_q;
    tag_nxt.idx   = j_r;
    tag_nxt.last  = (j_r == head.last_idx);
  end

  // sample sequencer and phase accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r   <= '0;
      acc_r <= '0;
    end else if (issue) begin
      acc_r <= acc_r + inc;
      j_r   <= pop ? '0 : j_r + IDX_W'(1);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= head_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // table address with quadrant mirroring
  always_comb begin
    quad  = p1_r[PB-1 -: 2];
    tidx  = p1_r[PB-3 -: TA];
    taddr = quad[0] ? ((TA+1)'(TAB_N) - {1'b0, tidx}) : {1'b0, tidx};
  end

  // rounding of gain times table value, half away from zero on the magnitude
  assign rnd   = prod3_r + (PROD_W'(1) << (SAMPLE_BITS - 2));
  assign r_ext = {1'b0, r4_r};

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= acc_r + offset;
      tag1_r  <= tag_nxt;
      tab2_r  <= QTAB[taddr];
      neg2_r  <= quad[1] ^ quad[0];
      tag2_r  <= tag1_r;
      prod3_r <= PROD_W'(tab2_r) * PROD_W'(cfg.carrier_gain);
      neg3_r  <= neg2_r;
      tag3_r  <= tag2_r;
      r4_r    <= rnd[PROD_W-1:TAB_W];
      neg4_r  <= neg3_r;
      tag4_r  <= tag3_r;
      sq5_r   <= SQ_W'(r4_r) * SQ_W'(r4_r);
      samp5_r <= neg4_r ? signed'(-r_ext) : signed'(r_ext);
      tag5_r  <= tag4_r;
    end
  end

  // baseband energy per sample, two times gain squared
  assign gsq = SQ_W'(cfg.baseband_gain) * SQ_W'(cfg.baseband_gain);

  always_ff @(posedge clk) begin
    bbe_r <= {gsq, 1'b0};
  end

  // saturating energy sums
  always_comb begin
    ben_sum = {1'b0, ben_r} + (ENERGY_W+1)'(bbe_r);
    cen_sum = {1'b0, cen_r} + (ENERGY_W+1)'(sq5_r);
    ben_nxt = ben_sum[ENERGY_W] ? '1 : ben_sum[ENERGY_W-1:0];
    cen_nxt = cen_sum[ENERGY_W] ? '1 : cen_sum[ENERGY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ben_r       <= '0;
      cen_r       <= '0;
    end else if (adv) begin
      out_valid_r <= v5_r;
      if (v5_r) begin
        ben_r <= ben_nxt;
        cen_r <= cen_nxt;
      end
    end
  end

  // output register payload
  assign lvl_pos = {1'b0, cfg.baseband_gain};

  always_ff @(posedge clk) begin
    if (adv && v5_r) begin
      carrier_r <= samp5_r;
      ilev_r    <= tag5_r.bit_i ? signed'(-lvl_pos) : signed'(lvl_pos);
      qlev_r    <= tag5_r.bit_q ? signed'(-lvl_pos) : signed'(lvl_pos);
      idx_r     <= tag5_r.idx;
      last_r    <= tag5_r.last;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.carrier_sample   = carrier_r;
  assign out_chan.in_phase_level   = ilev_r;
  assign out_chan.quadrature_level = qlev_r;
  assign out_chan.sample_index     = idx_r;
  assign out_chan.last_of_symbol   = last_r;
  assign out_chan.baseband_energy  = ben_r;
  assign out_chan.carrier_energy   = cen_r;

endmodule

`default_nettype wire

/* rtl/core/qpsk_carrier_modulator_top.sv */
// a front register and a 4-entry symbol queue take input while samples stream out
//   through the back-end stage registers and the output register, one sample per
//   cycle unless stalled; a symbol has samples_per_symbol samples (0 counts as 1,
//   capped at 64), paced by the sample sequencer of the back end
// reset: synchronous, active low; registers return to defaults, phase and energy
//   sums clear to zero, pipeline empties; no clearing pass
`default_nettype none

module qpsk_carrier_modulator_top #(
  parameter int unsigned PHASE_BITS      = qcm_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = qcm_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = qcm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  qcm_sym_if.sink                          in_chan,
  qcm_res_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [qcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qcm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import qcm_pkg::*;

  qcm_cfg_t cfg_r;
  logic     push_valid;
  logic     push_ready;
  qcm_sym_t push_entry;
  logic     head_valid;
  qcm_sym_t head;
  logic     pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_symbol <= SPS_RST;
      cfg_r.phase_increment    <= INC_RST;
      cfg_r.carrier_gain       <= CGAIN_RST;
      cfg_r.baseband_gain      <= BGAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPS:   cfg_r.samples_per_symbol <= cfg_data[SPS_W-1:0];
        CFG_INC:   cfg_r.phase_increment    <= cfg_data[INC_W-1:0];
        CFG_CGAIN: cfg_r.carrier_gain       <= cfg_data[GAIN_W-1:0];
        CFG_BGAIN: cfg_r.baseband_gain      <= cfg_data[GAIN_W-1:0];
        default:   cfg_r                    <= cfg_r;
      endcase
    end
  end

  qcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  qcm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  qcm_back #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

/* rtl/core/qcm_checker.sv */
`default_nettype none
`include "qpsk_carrier_modulator_top_defines.svh"

module qcm_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [qcm_pkg::LEVEL_W-1:0]    carrier_sample,
  input logic signed [qcm_pkg::LEVEL_W-1:0]    in_phase_level,
  input logic [qcm_pkg::IDX_W-1:0]             sample_index,
  input logic                                  last_of_symbol,
  input logic [qcm_pkg::ENERGY_W-1:0]          baseband_energy,
  input logic [qcm_pkg::ENERGY_W-1:0]          carrier_energy
);
  import qcm_pkg::*;

  // a stalled result holds
  `QCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(carrier_sample) && $stable(sample_index) && $stable(carrier_energy))

  // energy sums never fall
  `QCM_ASSERT_NEXT(a_energy_mono, 1'b1, (baseband_energy >= $past(baseband_energy)) && (carrier_energy >= $past(carrier_energy)))

  // back-to-back samples of one symbol count up
  `QCM_ASSERT_IMPL(a_index_step, (out_valid && out_ready && !last_of_symbol) ##1 out_valid, sample_index == $past(sample_index) + 6'd1)

  // level stays put within a symbol
  `QCM_ASSERT_IMPL(a_level_hold, (out_valid && out_ready && !last_of_symbol) ##1 out_valid, in_phase_level == $past(in_phase_level))

endmodule

bind qpsk_carrier_modulator_top qcm_checker u_qcm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .carrier_sample  (out_chan.carrier_sample),
  .in_phase_level  (out_chan.in_phase_level),
  .sample_index    (out_chan.sample_index),
  .last_of_symbol  (out_chan.last_of_symbol),
  .baseband_energy (out_chan.baseband_energy),
  .carrier_energy  (out_chan.carrier_energy)
);

`default_nettype wire

/* bench/qcm_sample_checker.sv */
`timescale 1ns / 100ps

module qcm_sample_checker
  import qcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  qcm_sym_if                    sym_mon,
  qcm_res_if                    res_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    samples_waiting
);

  localparam int unsigned TBL_BITS = TABLE_ADDR_BITS_DEF;
  localparam int unsigned TBL_N    = 1 << TBL_BITS;
  localparam int unsigned QUAD_MSB = PHASE_BITS_DEF - 1;
  localparam logic [63:0] AMP      = (64'd1 << (SAMPLE_BITS_DEF - 1)) - 64'd1;
  localparam int unsigned CAR_SHIFT = SAMPLE_BITS_DEF - 1;
  localparam logic [ENERGY_W-1:0] ENERGY_FULL = '1;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] carrier_sample;
    logic signed [LEVEL_W-1:0] in_phase_level;
    logic signed [LEVEL_W-1:0] quadrature_level;
    logic [IDX_W-1:0]          sample_index;
    logic                      last_of_symbol;
    logic [ENERGY_W-1:0]       baseband_energy;
    logic [ENERGY_W-1:0]       carrier_energy;
  } qcm_sample_t;

  // shadow registers and state of the modulator
  logic [SPS_W-1:0]            sps_reg;
  logic [INC_W-1:0]            inc_reg;
  logic [GAIN_W-1:0]           cgain_reg;
  logic [GAIN_W-1:0]           bgain_reg;
  logic [PHASE_BITS_DEF-1:0]   phase_acc;
  logic [ENERGY_W-1:0]         bb_energy_acc;
  logic [ENERGY_W-1:0]         car_energy_acc;

  int          quarter_cos [0:TBL_N];
  qcm_sample_t expected_samples [$];
  int          mismatches = 0;
  int          samples_seen = 0;
  int          waiting_q = 0;

  assign mismatch_count  = mismatches;
  assign samples_waiting = waiting_q;

  // one quarter-wave entry from the fixed-point cosine series
  function automatic int quarter_entry(input int unsigned k);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    longint      acc;
    int unsigned m;
    ang  = (64'(k) * HALF_PI_Q30 + 64'(TBL_N / 2)) >> TBL_BITS;
    ang2 = (ang * ang + (64'd1 << 29)) >> 30;
    term = 64'd1 << 30;
    acc  = longint'(term);
    for (m = 1; m <= 10; m++) begin
      term = (term * ang2 + (64'd1 << 29)) >> 30;
      term = term / 64'((2 * m - 1) * (2 * m));
      if (m % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (longint'(1) << 30)) begin
      acc = longint'(1) << 30;
    end
    return int'((64'(acc) * AMP + (64'd1 << 29)) >> 30);
  endfunction

  // quadrant folding of the quarter-wave table
  function automatic int cos_at(input logic [PHASE_BITS_DEF-1:0] p);
    logic [1:0]          quad;
    logic [TBL_BITS-1:0] idx;
    quad = p[QUAD_MSB -: 2];
    idx  = p[QUAD_MSB - 2 -: TBL_BITS];
    case (quad)
      2'd0: return quarter_cos[idx];
      2'd1: return -quarter_cos[TBL_N - idx];
      2'd2: return -quarter_cos[idx];
      default: return quarter_cos[TBL_N - idx];
    endcase
  endfunction

  function automatic logic [ENERGY_W-1:0] energy_add(input logic [ENERGY_W-1:0] acc,
                                                     input logic [63:0] step);
    logic [63:0] total;
    total = 64'(acc) + step;
    return (total > 64'(ENERGY_FULL)) ? ENERGY_FULL : total[ENERGY_W-1:0];
  endfunction

  // all carrier samples caused by one symbol
  function automatic void predict_symbol(input logic bi, input logic bq);
    int unsigned               count;
    int unsigned               j;
    logic [OFS_W-1:0]          ofs;
    logic [PHASE_BITS_DEF-1:0] offset;
    logic [LEVEL_W-1:0]        ilev;
    logic [LEVEL_W-1:0]        qlev;
    logic [63:0]               bb_step;
    logic [63:0]               mag;
    logic [63:0]               rnd;
    int                        cval;
    qcm_sample_t               s;
    count = 32'(sps_reg);
    if (count < 1) begin
      count = 1;
    end
    if (count > CNT_MAX) begin
      count = CNT_MAX;
    end
    case ({bi, bq})
      2'b00: ofs = OFS_00;
      2'b01: ofs = OFS_01;
      2'b11: ofs = OFS_11;
      default: ofs = OFS_10;
    endcase
    offset  = {ofs, {(PHASE_BITS_DEF - OFS_W){1'b0}}};
    ilev    = bi ? LEVEL_W'(-int'(bgain_reg)) : LEVEL_W'(bgain_reg);
    qlev    = bq ? LEVEL_W'(-int'(bgain_reg)) : LEVEL_W'(bgain_reg);
    bb_step = 64'd2 * 64'(bgain_reg) * 64'(bgain_reg);
    for (j = 0; j < count; j++) begin
      cval = cos_at(phase_acc + offset);
      mag  = (cval < 0) ? 64'(-cval) : 64'(cval);
      rnd  = (mag * 64'(cgain_reg) + (64'd1 << (CAR_SHIFT - 1))) >> CAR_SHIFT;
      bb_energy_acc  = energy_add(bb_energy_acc, bb_step);
      car_energy_acc = energy_add(car_energy_acc, rnd * rnd);
      s.carrier_sample   = (cval < 0) ? LEVEL_W'(-longint'(rnd)) : LEVEL_W'(rnd);
      s.in_phase_level   = ilev;
      s.quadrature_level = qlev;
      s.sample_index     = IDX_W'(j);
      s.last_of_symbol   = (j + 1 == count);
      s.baseband_energy  = bb_energy_acc;
      s.carrier_energy   = car_energy_acc;
      expected_samples.push_back(s);
      phase_acc = phase_acc + PHASE_BITS_DEF'(inc_reg);
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t mismatch at sample %0d: %s", $realtime, samples_seen, what);
    end
    mismatches++;
  endtask

  initial begin : build_table
    int unsigned k;
    for (k = 0; k <= TBL_N; k++) begin
      quarter_cos[k] = quarter_entry(k);
    end
  end

  // watch config writes, symbol transfers and sample transfers
  always @(posedge clk) begin
    qcm_sample_t want;
    if (!rst_n) begin
      expected_samples.delete();
      sps_reg        = SPS_RST;
      inc_reg        = INC_RST;
      cgain_reg      = CGAIN_RST;
      bgain_reg      = BGAIN_RST;
      phase_acc      = '0;
      bb_energy_acc  = '0;
      car_energy_acc = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPS:   sps_reg = cfg_data[SPS_W-1:0];
          CFG_INC:   inc_reg = cfg_data[INC_W-1:0];
          CFG_CGAIN: cgain_reg = cfg_data[GAIN_W-1:0];
          CFG_BGAIN: bgain_reg = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (sym_mon.valid && sym_mon.ready) begin
        predict_symbol(sym_mon.bit_i, sym_mon.bit_q);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer, carrier_sample %0d",
                                    res_mon.carrier_sample));
        end else begin
          want = expected_samples.pop_front();
          if (res_mon.carrier_sample !== want.carrier_sample)
            report_mismatch($sformatf("carrier_sample got %0d want %0d",
                                      res_mon.carrier_sample, want.carrier_sample));
          if (res_mon.in_phase_level !== want.in_phase_level)
            report_mismatch($sformatf("in_phase_level got %0d want %0d",
                                      res_mon.in_phase_level, want.in_phase_level));
          if (res_mon.quadrature_level !== want.quadrature_level)
            report_mismatch($sformatf("quadrature_level got %0d want %0d",
                                      res_mon.quadrature_level, want.quadrature_level));
          if (res_mon.sample_index !== want.sample_index)
            report_mismatch($sformatf("sample_index got %0d want %0d",
                                      res_mon.sample_index, want.sample_index));
          if (res_mon.last_of_symbol !== want.last_of_symbol)
            report_mismatch($sformatf("last_of_symbol got %b want %b",
                                      res_mon.last_of_symbol, want.last_of_symbol));
          if (res_mon.baseband_energy !== want.baseband_energy)
            report_mismatch($sformatf("baseband_energy got %0d want %0d",
                                      res_mon.baseband_energy, want.baseband_energy));
          if (res_mon.carrier_energy !== want.carrier_energy)
            report_mismatch($sformatf("carrier_energy got %0d want %0d",
                                      res_mon.carrier_energy, want.carrier_energy));
        end
        samples_seen++;
      end
    end
    waiting_q <= expected_samples.size();
  end

endmodule

/* bench/qpsk_carrier_modulator_top_test.sv */
`timescale 1ns / 100ps

module qpsk_carrier_modulator_top_test;
  import qcm_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int RANDOM_SYMBOLS  = 408;
  localparam int RANDOM_BLOCKS   = 12;
  localparam int SETTLE_CYCLES   = 16;
  localparam logic [INC_W-1:0]  HALF_TURN = 32'h8000_0000;
  localparam logic [GAIN_W-1:0] GAIN_TOP = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int mismatch_count;
  int samples_waiting;

  qcm_sym_if sym_chan ();
  qcm_res_if res_chan ();

  qpsk_carrier_modulator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (sym_chan),
    .out_chan  (res_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qcm_sample_checker scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .sym_mon         (sym_chan),
    .res_mon         (res_chan),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .samples_waiting (samples_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    res_chan.ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
  end

  // stop when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((sym_chan.valid && sym_chan.ready) || (res_chan.valid && res_chan.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // hold off new symbols until every expected sample has arrived
  task automatic wait_idle();
    sym_chan.valid <= 1'b0;
    do @(posedge clk); while (samples_waiting != 0);
  endtask

  task automatic send_symbol(input logic bi, input logic bq);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      sym_chan.valid <= 1'b0;
      @(posedge clk);
    end
    sym_chan.valid <= 1'b1;
    sym_chan.bit_i <= bi;
    sym_chan.bit_q <= bq;
    do @(posedge clk); while (!sym_chan.ready);
  endtask

  // back-to-back register writes with junk in the unused upper bits
  task automatic apply_settings(input logic [SPS_W-1:0] sps, input logic [INC_W-1:0] inc,
                                input logic [GAIN_W-1:0] cg, input logic [GAIN_W-1:0] bg);
    logic [CFG_DATA_W-1:0] junk;
    wait_idle();
    junk = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPS;
    cfg_data  <= {junk[CFG_DATA_W-1:SPS_W], sps};
    @(posedge clk);
    cfg_index <= CFG_INC;
    cfg_data  <= inc;
    @(posedge clk);
    cfg_index <= CFG_CGAIN;
    cfg_data  <= {junk[CFG_DATA_W-1:GAIN_W], cg};
    @(posedge clk);
    cfg_index <= CFG_BGAIN;
    cfg_data  <= {~junk[CFG_DATA_W-1:GAIN_W], bg};
    @(posedge clk);
    cfg_we  <= 1'b0;
  endtask

  // mostly short symbols, sometimes long or out of range
  task automatic apply_random_settings();
    logic [SPS_W-1:0]  sps;
    logic [INC_W-1:0]  inc;
    logic [GAIN_W-1:0] cg;
    logic [GAIN_W-1:0] bg;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 70) sps = SPS_W'($urandom_range(8, 1));
    else if (pick < 85) sps = SPS_W'($urandom_range(16, 0));
    else if (pick < 95) sps = SPS_W'($urandom_range(63, 17));
    else sps = SPS_W'($urandom_range(127, 64));
    if ($urandom_range(9) == 0) inc = $urandom_range(1) ? '1 : '0;
    else inc = $urandom;
    if ($urandom_range(9) == 0) cg = $urandom_range(1) ? GAIN_TOP : '0;
    else cg = GAIN_W'($urandom_range(32767));
    if ($urandom_range(9) == 0) bg = $urandom_range(1) ? GAIN_TOP : '0;
    else bg = GAIN_W'($urandom_range(32767));
    apply_settings(sps, inc, cg, bg);
  endtask

  initial begin : stimulus
    int n;
    int ph;
    int blk;
    rst_n          <= 1'b0;
    sym_chan.valid <= 1'b0;
    sym_chan.bit_i <= 1'b0;
    sym_chan.bit_q <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_SPS;
    cfg_data       <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // every bit pair at the reset settings
    for (n = 0; n < 4; n++) send_symbol(n[1], n[0]);

    // zero samples per symbol, full-scale gains, largest step
    apply_settings(7'd0, 32'hFFFF_FFFF, GAIN_TOP, GAIN_TOP);
    for (n = 0; n < 4; n++) send_symbol(n[0], n[1]);

    // longest symbol, frozen phase, silent outputs
    apply_settings(7'd64, 32'h0, '0, '0);
    send_symbol(1'b0, 1'b1);
    send_symbol(1'b1, 1'b0);

    // samples per symbol above the cap
    apply_settings(7'd127, 32'h4000_0000, GAIN_TOP, 15'd1);
    send_symbol(1'b1, 1'b1);
    send_symbol(1'b0, 1'b0);
    apply_settings(7'd65, 32'h1234_5678, 15'd1, GAIN_TOP);
    send_symbol(1'b1, 1'b0);
    send_symbol(1'b0, 1'b1);

    // one sample per symbol, half-turn step
    apply_settings(7'd1, HALF_TURN, 15'd16384, 15'd16384);
    for (n = 0; n < 4; n++) send_symbol(n[1], n[1] ^ n[0]);

    // random symbols under each idling pattern
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
        default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
      endcase
      for (blk = 0; blk < RANDOM_BLOCKS / 4; blk++) begin
        apply_random_settings();
        repeat (RANDOM_SYMBOLS / RANDOM_BLOCKS)
          send_symbol(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && samples_waiting == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
